### rtl/vbp_pkg.sv
// ----------------------------------------------------------------------------
// vbp_pkg
// Shared widths, display mode codes and fixed colours for the byte pair
// pixel decoder.
// ----------------------------------------------------------------------------
package vbp_pkg;

  // field widths
  localparam int ADDR_W   = 13;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 4;
  localparam int COLOUR_W = 5;
  localparam int PIX_X_W  = 10;
  localparam int PIX_Y_W  = 9;

  // pixels per group
  localparam int PIXELS    = 16;
  localparam int PIX_CNT_W = 4;

  // default geometry
  localparam int DEF_GROUPS_PER_LINE  = 40;
  localparam int DEF_PALETTE_AREA_END = 4000;
  localparam int DEF_BORDER_X         = 32;
  localparam int DEF_BORDER_Y         = 32;

  // palette screen attribute test
  localparam logic [BYTE_W-1:0] PAL_ATTR_MASK  = 8'h78;
  localparam logic [BYTE_W-1:0] PAL_ATTR_MATCH = 8'h30;

  // palette screen fixed colours
  localparam logic [COLOUR_W-1:0] FIXED_COLOUR_A = 5'd16;
  localparam logic [COLOUR_W-1:0] FIXED_COLOUR_B = 5'd17;

  // display modes
  typedef enum logic [MODE_W-1:0] {
    MODE_COL40    = 4'd0,
    MODE_BITMAP4  = 4'd1,
    MODE_PAGE1    = 4'd2,
    MODE_PAGE2    = 4'd3,
    MODE_STACK2   = 4'd4,
    MODE_COL80    = 4'd5,
    MODE_STACK4   = 4'd6,
    MODE_BITMAP4B = 4'd7,
    MODE_BITMAP16 = 4'd8,
    MODE_PALETTE  = 4'd9
  } mode_t;

endpackage

### rtl/vbp_in_if.sv
// ----------------------------------------------------------------------------
// vbp_in_if
// Input channel: one video memory group (address, shape byte, colour byte).
// ----------------------------------------------------------------------------
interface vbp_in_if;
  logic                        valid;
  logic                        ready;
  logic [vbp_pkg::ADDR_W-1:0]  vram_address;
  logic [vbp_pkg::BYTE_W-1:0]  shape_byte;
  logic [vbp_pkg::BYTE_W-1:0]  colour_byte;

  modport source (output valid, vram_address, shape_byte, colour_byte, input ready);
  modport sink   (input valid, vram_address, shape_byte, colour_byte, output ready);
endinterface

### rtl/vbp_out_if.sv
// ----------------------------------------------------------------------------
// vbp_out_if
// Output channel: one pixel with colour index and screen position.
// ----------------------------------------------------------------------------
interface vbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [vbp_pkg::COLOUR_W-1:0]  colour_index;
  logic [vbp_pkg::PIX_X_W-1:0]   pixel_x;
  logic [vbp_pkg::PIX_Y_W-1:0]   pixel_y;
  logic                          last_pixel;

  modport source (output valid, colour_index, pixel_x, pixel_y, last_pixel, input ready);
  modport sink   (input valid, colour_index, pixel_x, pixel_y, last_pixel, output ready);
endinterface

### rtl/video_byte_pair_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// video_byte_pair_pixel_decoder_top
// Decodes one video memory group into sixteen pixels under the display mode.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_port   in   valid / ready        vram_address, shape_byte, colour_byte
//  out_port  out  valid / ready        colour_index, pixel_x, pixel_y, last_pixel
//  cfg       in   cfg_wr_en            cfg_wr_data (display mode)
//
//  each item gives sixteen pixels, one per cycle while out_port is ready, sent
//  by the output serialiser; new items are accepted while it is still busy
//  three stages (reciprocal multiply, remainder, correct and decode) feed it
//  reset (rst_n low, synchronous) empties all stages and sets mode col40
//  a stall on out_port holds the current pixel; items queue in the stages
// ----------------------------------------------------------------------------
module video_byte_pair_pixel_decoder_top #(
  parameter int GROUPS_PER_LINE  = vbp_pkg::DEF_GROUPS_PER_LINE,
  parameter int PALETTE_AREA_END = vbp_pkg::DEF_PALETTE_AREA_END,
  parameter int BORDER_X         = vbp_pkg::DEF_BORDER_X,
  parameter int BORDER_Y         = vbp_pkg::DEF_BORDER_Y
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [vbp_pkg::MODE_W-1:0]  cfg_wr_data,
  vbp_in_if.sink                      in_port,
  vbp_out_if.source                   out_port
);

  localparam int ADDR_W    = vbp_pkg::ADDR_W;
  localparam int BYTE_W    = vbp_pkg::BYTE_W;
  localparam int COLOUR_W  = vbp_pkg::COLOUR_W;
  localparam int PIXELS    = vbp_pkg::PIXELS;
  localparam int PIX_CNT_W = vbp_pkg::PIX_CNT_W;

  // divider constants: quotient estimate is never more than one short
  localparam int GPL_EFF   = (GROUPS_PER_LINE == 0) ? 1 : GROUPS_PER_LINE;
  localparam int GPL_W     = 8;
  localparam int DIV_SHIFT = ADDR_W + 1;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = ADDR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DIV_SHIFT) / GPL_EFF);
  localparam logic [GPL_W-1:0]   GPL_C = GPL_W'(GPL_EFF);
  localparam logic [ADDR_W-1:0]  PAL_END_C = ADDR_W'(PALETTE_AREA_END);
  localparam logic [PIX_CNT_W-1:0] LAST_CNT = PIX_CNT_W'(PIXELS - 1);

  typedef logic [PIXELS-1:0][COLOUR_W-1:0] pix_vec_t;

  // pixel decode for one group
  function automatic pix_vec_t decode_pixels(
    input vbp_pkg::mode_t    mode,
    input logic [ADDR_W-1:0] addr,
    input logic [BYTE_W-1:0] shp,
    input logic [BYTE_W-1:0] col
  );
    pix_vec_t px;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [2:0] p;
    logic [1:0] b;
    logic [COLOUR_W-1:0] on_c;
    logic [COLOUR_W-1:0] off_c;
    fg = {~col[6], col[5:3]};
    bg = {~col[7], col[2:0]};
    if ((col & vbp_pkg::PAL_ATTR_MASK) == vbp_pkg::PAL_ATTR_MATCH) begin
      on_c  = vbp_pkg::FIXED_COLOUR_A;
      off_c = vbp_pkg::FIXED_COLOUR_B;
    end else begin
      on_c  = vbp_pkg::FIXED_COLOUR_B;
      off_c = vbp_pkg::FIXED_COLOUR_A;
    end
    for (int i = 0; i < PIXELS; i++) begin
      p = 3'(7 - (i >> 1));
      b = 2'(i >> 2);
      px[i] = {1'b0, (shp[p] ? fg : bg)};
      case (mode)
        vbp_pkg::MODE_BITMAP4: px[i] = COLOUR_W'({shp[p], col[p]});
        vbp_pkg::MODE_PAGE1:   px[i] = COLOUR_W'(shp[p]);
        vbp_pkg::MODE_PAGE2:   px[i] = COLOUR_W'({shp[p], 1'b0});
        vbp_pkg::MODE_STACK2:  px[i] = shp[p] ? COLOUR_W'(1) :
                                       (col[p] ? COLOUR_W'(2) : COLOUR_W'(0));
        vbp_pkg::MODE_COL80: begin
          if (i < 8) px[i] = COLOUR_W'(shp[3'(7 - i)]);
          else       px[i] = COLOUR_W'(col[3'(15 - i)]);
        end
        vbp_pkg::MODE_STACK4: begin
          if      (shp[3'(7 - b)]) px[i] = COLOUR_W'(1);
          else if (shp[3'(3 - b)]) px[i] = COLOUR_W'(2);
          else if (col[3'(7 - b)]) px[i] = COLOUR_W'(3);
          else if (col[3'(3 - b)]) px[i] = COLOUR_W'(4);
          else                     px[i] = COLOUR_W'(0);
        end
        vbp_pkg::MODE_BITMAP4B: begin
          if (i < 8) px[i] = COLOUR_W'(shp[3'(6 - 2 * (i >> 1)) +: 2]);
          else       px[i] = COLOUR_W'(col[3'(6 - 2 * ((i - 8) >> 1)) +: 2]);
        end
        vbp_pkg::MODE_BITMAP16: begin
          case (b)
            2'd0:    px[i] = COLOUR_W'(shp[7:4]);
            2'd1:    px[i] = COLOUR_W'(shp[3:0]);
            2'd2:    px[i] = COLOUR_W'(col[7:4]);
            default: px[i] = COLOUR_W'(col[3:0]);
          endcase
        end
        vbp_pkg::MODE_PALETTE: begin
          if (addr < PAL_END_C) px[i] = shp[p] ? on_c : off_c;
        end
        default: ;
      endcase
    end
    return px;
  endfunction

  // mode register
  vbp_pkg::mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vbp_pkg::MODE_COL40;
    end else if (cfg_wr_en) begin
      mode_r <= vbp_pkg::mode_t'(cfg_wr_data);
    end
  end

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, ser_valid_r;
  logic load1, load2, load3, ser_take;
  logic [PIX_CNT_W-1:0] cnt_r;
  logic [PIX_CNT_W-1:0] cnt_nxt;
  logic out_last;
  logic out_fire;

  assign out_last = (cnt_r == LAST_CNT);
  assign out_fire = ser_valid_r && out_port.ready;
  assign ser_take = !ser_valid_r || (out_fire && out_last);
  assign load3    = !v3_r || ser_take;
  assign load2    = !v2_r || load3;
  assign load1    = !v1_r || load2;
  assign in_port.ready = load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      ser_valid_r <= 1'b0;
    end else begin
      if (load1)    v1_r        <= in_port.valid;
      if (load2)    v2_r        <= v1_r;
      if (load3)    v3_r        <= v2_r;
      if (ser_take) ser_valid_r <= v3_r;
    end
  end

  // stage 1: capture item and reciprocal product
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_shape_r, s1_colour_r;
  logic [PROD_W-1:0] s1_prod_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_addr_r   <= in_port.vram_address;
      s1_shape_r  <= in_port.shape_byte;
      s1_colour_r <= in_port.colour_byte;
      s1_prod_r   <= PROD_W'(in_port.vram_address) * PROD_W'(RECIP);
    end
  end

  // stage 2: quotient estimate and remainder estimate
  logic [ADDR_W-1:0]       q_est;
  logic [ADDR_W+GPL_W-1:0] q_times_d;
  logic [ADDR_W-1:0] s2_addr_r, s2_q_r;
  logic [BYTE_W-1:0] s2_shape_r, s2_colour_r;
  logic [GPL_W-1:0]  s2_rem_r;

  assign q_est     = s1_prod_r[DIV_SHIFT +: ADDR_W];
  assign q_times_d = (ADDR_W+GPL_W)'(q_est) * (ADDR_W+GPL_W)'(GPL_C);

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_addr_r   <= s1_addr_r;
      s2_shape_r  <= s1_shape_r;
      s2_colour_r <= s1_colour_r;
      s2_q_r      <= q_est;
      s2_rem_r    <= GPL_W'((ADDR_W+GPL_W)'(s1_addr_r) - q_times_d);
    end
  end

  // stage 3: correct quotient, form coordinates, decode pixels
  logic                       rem_over;
  logic [ADDR_W-1:0]          q_fix;
  logic [GPL_W-1:0]           r_fix;
  logic [vbp_pkg::PIX_X_W-1:0] x0_calc, s3_x0_r;
  logic [vbp_pkg::PIX_Y_W-1:0] y_calc, s3_y_r;
  pix_vec_t                   s3_px_r;

  assign rem_over = (s2_rem_r >= GPL_C);
  assign q_fix    = s2_q_r + ADDR_W'(rem_over);
  assign r_fix    = rem_over ? (s2_rem_r - GPL_C) : s2_rem_r;
  assign x0_calc  = vbp_pkg::PIX_X_W'(BORDER_X) + vbp_pkg::PIX_X_W'({r_fix, 4'b0000});
  assign y_calc   = vbp_pkg::PIX_Y_W'(BORDER_Y) + vbp_pkg::PIX_Y_W'({q_fix, 1'b0});

  always_ff @(posedge clk) begin
    if (load3) begin
      s3_x0_r <= x0_calc;
      s3_y_r  <= y_calc;
      s3_px_r <= decode_pixels(mode_r, s2_addr_r, s2_shape_r, s2_colour_r);
    end
  end

  // output serialiser: one pixel per cycle while out_port is ready
  pix_vec_t                    ser_px_r;
  logic [vbp_pkg::PIX_X_W-1:0] ser_x0_r;
  logic [vbp_pkg::PIX_Y_W-1:0] ser_y_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ser_take)      cnt_nxt = '0;
    else if (out_fire) cnt_nxt = cnt_r + PIX_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_px_r <= s3_px_r;
      ser_x0_r <= s3_x0_r;
      ser_y_r  <= s3_y_r;
    end
  end

  assign out_port.valid        = ser_valid_r;
  assign out_port.colour_index = ser_px_r[cnt_r];
  assign out_port.pixel_x      = ser_x0_r + vbp_pkg::PIX_X_W'(cnt_r);
  assign out_port.pixel_y      = ser_y_r;
  assign out_port.last_pixel   = out_last;

  // checks
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last && !v3_r) |=> !ser_valid_r)
    else $error("serialiser not empty after last pixel");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last) |=> (cnt_r == $past(cnt_r) + PIX_CNT_W'(1)))
    else $error("pixel counter did not advance");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_valid_r && !out_port.ready) |=> ($stable(cnt_r) && $stable(ser_x0_r)))
    else $error("pixel changed during stall");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_port.ready |-> (v1_r && v2_r && v3_r && ser_valid_r))
    else $error("input blocked with a free stage");

endmodule

### test/tb_video_byte_pair_pixel_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_byte_pair_pixel_decoder_top
// Self-checking bench for the byte pair pixel decoder. Each group sent in is
// expanded by a local model into its sixteen expected pixels (colour index
// and screen position). Every pixel that leaves the block is checked against
// them in order. The run covers every display mode, the unknown mode codes,
// the palette screen area edges, random idling on both channels, a long
// output hold-off and a pause on the input side.
// ----------------------------------------------------------------------------
module tb_video_byte_pair_pixel_decoder_top;

  localparam int ADDR_W   = vbp_pkg::ADDR_W;
  localparam int BYTE_W   = vbp_pkg::BYTE_W;
  localparam int MODE_W   = vbp_pkg::MODE_W;
  localparam int COLOUR_W = vbp_pkg::COLOUR_W;
  localparam int PIX_X_W  = vbp_pkg::PIX_X_W;
  localparam int PIX_Y_W  = vbp_pkg::PIX_Y_W;
  localparam int PIXELS   = vbp_pkg::PIXELS;

  localparam int DEF_GROUPS_PER_LINE  = vbp_pkg::DEF_GROUPS_PER_LINE;
  localparam int DEF_PALETTE_AREA_END = vbp_pkg::DEF_PALETTE_AREA_END;
  localparam int DEF_BORDER_X         = vbp_pkg::DEF_BORDER_X;
  localparam int DEF_BORDER_Y         = vbp_pkg::DEF_BORDER_Y;

  // mode codes past the documented set, decoded as col40
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 4'd10;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 4'd15;

  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam int MAX_IDLE     = 19;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [PIX_X_W-1:0]  x;
    logic [PIX_Y_W-1:0]  y;
    logic                last;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [MODE_W-1:0] cfg_wr_data;

  vbp_in_if  in_if ();
  vbp_out_if out_if ();

  video_byte_pair_pixel_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_port    (in_if),
    .out_port   (out_if)
  );

  // display mode as the block holds it
  logic [MODE_W-1:0] mode_now;

  pixel_t expected_pixels[$];
  int     error_count;
  int     groups_sent;
  int     pixels_checked;
  int     mode_writes;
  bit     sender_idle;
  bit     receiver_idle;
  int     hold_request;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // colour index of pixel k of one group
  function automatic logic [COLOUR_W-1:0] pixel_colour(logic [MODE_W-1:0] mode,
                                                       logic [ADDR_W-1:0] addr,
                                                       logic [BYTE_W-1:0] shape,
                                                       logic [BYTE_W-1:0] colr,
                                                       int k);
    logic sp;
    logic cp;
    logic match;
    int   b;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    logic [COLOUR_W-1:0] on_c;
    logic [COLOUR_W-1:0] off_c;
    sp = shape[7 - k / 2];
    cp = colr[7 - k / 2];
    b  = k / 4;
    // col40: clear attribute top bits lift the colour into the upper half
    fg = {1'b0, ~colr[6], colr[5:3]};
    bg = {1'b0, ~colr[7], colr[2:0]};
    pixel_colour = sp ? fg : bg;
    case (mode)
      vbp_pkg::MODE_BITMAP4: pixel_colour = {3'b000, sp, cp};
      vbp_pkg::MODE_PAGE1:   pixel_colour = sp ? 5'd1 : 5'd0;
      vbp_pkg::MODE_PAGE2:   pixel_colour = sp ? 5'd2 : 5'd0;
      vbp_pkg::MODE_STACK2:  pixel_colour = sp ? 5'd1 : (cp ? 5'd2 : 5'd0);
      vbp_pkg::MODE_COL80: begin
        if (k < 8) pixel_colour = {4'b0000, shape[7 - k]};
        else       pixel_colour = {4'b0000, colr[15 - k]};
      end
      vbp_pkg::MODE_STACK4: begin
        if (shape[7 - b])      pixel_colour = 5'd1;
        else if (shape[3 - b]) pixel_colour = 5'd2;
        else if (colr[7 - b])  pixel_colour = 5'd3;
        else if (colr[3 - b])  pixel_colour = 5'd4;
        else                   pixel_colour = 5'd0;
      end
      vbp_pkg::MODE_BITMAP4B: begin
        if (k < 8) pixel_colour = {3'b000, shape[7 - 2 * (k / 2) -: 2]};
        else       pixel_colour = {3'b000, colr[7 - 2 * ((k - 8) / 2) -: 2]};
      end
      vbp_pkg::MODE_BITMAP16: begin
        case (b)
          0:       pixel_colour = {1'b0, shape[7:4]};
          1:       pixel_colour = {1'b0, shape[3:0]};
          2:       pixel_colour = {1'b0, colr[7:4]};
          default: pixel_colour = {1'b0, colr[3:0]};
        endcase
      end
      vbp_pkg::MODE_PALETTE: begin
        // outside the palette area the col40 rule stays
        if (addr < DEF_PALETTE_AREA_END) begin
          match = ((colr & vbp_pkg::PAL_ATTR_MASK) == vbp_pkg::PAL_ATTR_MATCH);
          on_c  = match ? vbp_pkg::FIXED_COLOUR_A : vbp_pkg::FIXED_COLOUR_B;
          off_c = match ? vbp_pkg::FIXED_COLOUR_B : vbp_pkg::FIXED_COLOUR_A;
          pixel_colour = sp ? on_c : off_c;
        end
      end
      default: ;
    endcase
  endfunction

  // queue the sixteen pixels of one accepted group
  task automatic predict_group(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] shape,
                               logic [BYTE_W-1:0] colr);
    int unsigned row;
    int unsigned grp;
    pixel_t      p;
    row = addr / DEF_GROUPS_PER_LINE;
    grp = addr % DEF_GROUPS_PER_LINE;
    for (int k = 0; k < PIXELS; k++) begin
      p.colour = pixel_colour(mode_now, addr, shape, colr, k);
      p.x      = PIX_X_W'(DEF_BORDER_X + grp * PIXELS + k);
      p.y      = PIX_Y_W'(DEF_BORDER_Y + row * 2);
      p.last   = (k == PIXELS - 1);
      expected_pixels.push_back(p);
    end
  endtask

  // offer one item, after a random gap when sender_idle is set, and wait for its accept
  task automatic send_group(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] shape,
                            logic [BYTE_W-1:0] colr);
    int gap;
    gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.vram_address <= addr;
    in_if.shape_byte   <= shape;
    in_if.colour_byte  <= colr;
    do @(posedge clk); while (!in_if.ready);
    predict_group(addr, shape, colr);
    groups_sent++;
  endtask

  // stop offering and wait until every expected pixel has arrived
  task automatic drain;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode register write, only with the block idle
  task automatic write_display_mode(logic [MODE_W-1:0] mode);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    mode_now     = mode;
    mode_writes++;
  endtask

  // address spread with weight on the edges of the screen and palette area
  function automatic logic [ADDR_W-1:0] random_address;
    case ($urandom_range(0, 9))
      0:       random_address = '0;
      1:       random_address = ADDR_MAX;
      2:       random_address = ADDR_W'(DEF_PALETTE_AREA_END - 1);
      3:       random_address = ADDR_W'(DEF_PALETTE_AREA_END);
      4:       random_address = ADDR_W'($urandom_range(0, 203) * DEF_GROUPS_PER_LINE
                                        + DEF_GROUPS_PER_LINE - 1);
      5:       random_address = ADDR_W'($urandom_range(0, DEF_PALETTE_AREA_END - 1));
      default: random_address = ADDR_W'($urandom_range(0, ADDR_MAX));
    endcase
  endfunction

  // colour byte, half of the time forced onto the palette attribute match
  function automatic logic [BYTE_W-1:0] random_colour;
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom);
    if ($urandom_range(0, 1)) c = (c & ~vbp_pkg::PAL_ATTR_MASK) | vbp_pkg::PAL_ATTR_MATCH;
    random_colour = c;
  endfunction

  // ---------------------------------------------------------------- tests

  // every mode once, reset mode first, palette and unknown-mode cases
  task automatic test_directed;
    send_group('0, 8'hA5, 8'h00);
    send_group(ADDR_MAX, 8'hFF, 8'hFF);
    write_display_mode(vbp_pkg::MODE_BITMAP4);
    send_group(ADDR_W'(39), 8'h5A, 8'hC3);
    write_display_mode(vbp_pkg::MODE_PAGE1);
    send_group(ADDR_W'(40), 8'hF0, 8'h0F);
    write_display_mode(vbp_pkg::MODE_PAGE2);
    send_group(ADDR_W'(1234), 8'h0F, 8'hF0);
    write_display_mode(vbp_pkg::MODE_STACK2);
    send_group(ADDR_W'(5000), 8'hAA, 8'h55);
    write_display_mode(vbp_pkg::MODE_COL80);
    send_group(ADDR_W'(81), 8'h96, 8'h69);
    write_display_mode(vbp_pkg::MODE_STACK4);
    send_group(ADDR_W'(2000), 8'h81, 8'h42);
    send_group(ADDR_W'(2001), 8'h00, 8'h18);
    write_display_mode(vbp_pkg::MODE_BITMAP4B);
    send_group(ADDR_W'(7777), 8'h1B, 8'hE4);
    write_display_mode(vbp_pkg::MODE_BITMAP16);
    send_group(ADDR_W'(3), 8'h12, 8'hEF);
    // palette screen: attribute match, no match, area edges
    write_display_mode(vbp_pkg::MODE_PALETTE);
    send_group('0, 8'hF0, 8'h30);
    send_group(ADDR_W'(DEF_PALETTE_AREA_END - 1), 8'hC3, 8'h00);
    send_group(ADDR_W'(DEF_PALETTE_AREA_END - 1), 8'h3C, 8'hB7);
    send_group(ADDR_W'(DEF_PALETTE_AREA_END), 8'h0F, 8'h30);
    send_group(ADDR_MAX, 8'h00, 8'h78);
    // unknown mode codes fall back to col40
    write_display_mode(MODE_UNKNOWN_LO);
    send_group(ADDR_W'(100), 8'h3C, 8'h47);
    write_display_mode(MODE_UNKNOWN_HI);
    send_group(ADDR_W'(8000), 8'hC3, 8'hB8);
  endtask

  // random content across random mode settings and idling patterns
  task automatic test_random_modes;
    logic [MODE_W-1:0] mode;
    for (int phase = 0; phase < 13; phase++) begin
      if (phase == 0)      mode = vbp_pkg::MODE_COL40;
      else if (phase == 1) mode = MODE_UNKNOWN_HI;
      else if (phase == 2) mode = vbp_pkg::MODE_PALETTE;
      else                 mode = MODE_W'($urandom_range(0, MODE_UNKNOWN_HI));
      write_display_mode(mode);
      sender_idle   = (phase % 4 != 1);
      receiver_idle = (phase % 3 != 2);
      for (int n = 0; n < 30; n++)
        send_group(random_address(), BYTE_W'($urandom), random_colour());
    end
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // long output hold-off while items keep coming, so the input stalls
  task automatic test_output_hold;
    write_display_mode(vbp_pkg::MODE_BITMAP16);
    sender_idle  = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 20; n++)
      send_group(random_address(), BYTE_W'($urandom), random_colour());
    sender_idle = 1'b1;
  endtask

  // sender pauses until the block has emptied, then resumes
  task automatic test_sender_pause;
    write_display_mode(vbp_pkg::MODE_PALETTE);
    for (int n = 0; n < 10; n++)
      send_group(random_address(), BYTE_W'($urandom), random_colour());
    drain();
    for (int n = 0; n < 10; n++)
      send_group(random_address(), BYTE_W'($urandom), random_colour());
  endtask

  // full rate on both sides
  task automatic test_full_rate;
    write_display_mode(vbp_pkg::MODE_STACK4);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    for (int n = 0; n < 30; n++)
      send_group(random_address(), BYTE_W'($urandom), BYTE_W'($urandom));
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_if.valid        = 1'b0;
    in_if.vram_address = '0;
    in_if.shape_byte   = '0;
    in_if.colour_byte  = '0;
    mode_now           = vbp_pkg::MODE_COL40;
    error_count        = 0;
    groups_sent        = 0;
    pixels_checked     = 0;
    mode_writes        = 0;
    sender_idle        = 1'b1;
    receiver_idle      = 1'b1;
    hold_request       = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_modes();
    test_output_hold();
    test_sender_pause();
    test_full_rate();
    drain();

    $display("covered %0d groups and %0d pixels over %0d mode writes", groups_sent,
             pixels_checked, mode_writes);
    $display("all display modes, unknown codes, palette area edges and both-side stalls");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver: random stalls per pixel, plus a counted hold-off on request
  initial begin
    int gap;
    int hold;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      gap = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // compare each accepted pixel with the oldest expected one
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, got colour %0d x %0d y %0d last %0b",
                 $time, out_if.colour_index, out_if.pixel_x, out_if.pixel_y,
                 out_if.last_pixel);
        error_count++;
      end else begin
        exp_p = expected_pixels.pop_front();
        pixels_checked++;
        if (out_if.colour_index !== exp_p.colour) begin
          $display("%0t colour_index: expected %0d, got %0d", $time, exp_p.colour,
                   out_if.colour_index);
          error_count++;
        end
        if (out_if.pixel_x !== exp_p.x) begin
          $display("%0t pixel_x: expected %0d, got %0d", $time, exp_p.x, out_if.pixel_x);
          error_count++;
        end
        if (out_if.pixel_y !== exp_p.y) begin
          $display("%0t pixel_y: expected %0d, got %0d", $time, exp_p.y, out_if.pixel_y);
          error_count++;
        end
        if (out_if.last_pixel !== exp_p.last) begin
          $display("%0t last_pixel: expected %0b, got %0b", $time, exp_p.last,
                   out_if.last_pixel);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d pixels still expected", expected_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
rtl/vbp_pkg.sv
rtl/vbp_in_if.sv
rtl/vbp_out_if.sv
rtl/video_byte_pair_pixel_decoder_top.sv
test/tb_video_byte_pair_pixel_decoder_top.sv
